### hw/rtl/cstp_pkg.sv
// Shared types, sizes and helpers of the call stack time profiler.
// Used by the memory modules, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package cstp_pkg;

  // Table sizes
  localparam int unsigned METHOD_SLOTS = 256;
  localparam int unsigned STACK_FRAMES = 64;

  // Derived widths: method index, frame address, stack depth
  localparam int unsigned MI_W = $clog2(METHOD_SLOTS);
  localparam int unsigned SA_W = $clog2(STACK_FRAMES);
  localparam int unsigned DP_W = $clog2(STACK_FRAMES + 1);

  typedef enum logic {
    OP_ENTER = 1'b0,
    OP_LEAVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    op_e         op;
    logic [7:0]  method_id;
    logic [63:0] timestamp;
  } cstp_in_t;

  // Output beat
  typedef struct packed {
    status_e     status;
    logic [31:0] calls;
    logic [6:0]  active_count;
    logic [63:0] cum_time;
    logic [63:0] outer_time;
    logic [63:0] child_time;
    logic        flawed;
    logic [63:0] grand_total;
    logic [6:0]  depth;
  } cstp_out_t;

  // One entry of the per-method statistics table
  typedef struct packed {
    logic [31:0] calls;
    logic [6:0]  active;
    logic        flawed;
    logic [63:0] cum;
    logic [63:0] outer;
    logic [63:0] child;
  } cstp_mth_t;

  // One shadow stack frame
  typedef struct packed {
    logic [MI_W-1:0] meth;
    logic [63:0]     entry;
    logic [63:0]     child;
  } cstp_frame_t;

  // Access request to the method table
  typedef struct packed {
    logic            re;
    logic [MI_W-1:0] raddr;
    logic            we;
    logic [MI_W-1:0] waddr;
    cstp_mth_t       wdata;
  } cstp_mreq_t;

  // Access request to the frame stack
  typedef struct packed {
    logic            re;
    logic [SA_W-1:0] raddr;
    logic            we;
    logic [SA_W-1:0] waddr;
    cstp_frame_t     wdata;
  } cstp_freq_t;

  // Reduce a method id into the table range by restoring subtraction
  function automatic logic [MI_W-1:0] mth_idx(input logic [7:0] id);
    logic [16:0] r;
    logic [16:0] sub;
    r   = {9'd0, id};
    sub = '0;
    if (METHOD_SLOTS < 256) begin
      for (int k = 7; k >= 0; k--) begin
        sub = 17'(METHOD_SLOTS) << k;
        if (r >= sub) begin
          r = r - sub;
        end
      end
    end
    return r[MI_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cstp_mtab.sv
// Per-method statistics memory: one write port, one registered read port.
// Depends on cstp_pkg for the entry and request types.
`timescale 1ns / 1ps
`default_nettype none

module cstp_mtab
  import cstp_pkg::*;
(
  input  wire             clk_i,
  input  wire cstp_mreq_t req_i,
  output cstp_mth_t       rdata_o
);

  cstp_mth_t mem_q [METHOD_SLOTS];
  cstp_mth_t rdata_q;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/cstp_fstack.sv
// Shadow call stack memory: one write port, one registered read port.
// Depends on cstp_pkg for the frame and request types.
`timescale 1ns / 1ps
`default_nettype none

module cstp_fstack
  import cstp_pkg::*;
(
  input  wire             clk_i,
  input  wire cstp_freq_t req_i,
  output cstp_frame_t     rdata_o
);

  cstp_frame_t mem_q [STACK_FRAMES];
  cstp_frame_t rdata_q;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/call_stack_time_profiler_top.sv
// Top level of the call stack time profiler: sequencer, counters, output register.
// Depends on cstp_pkg, cstp_mtab and cstp_fstack.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted enter or leave beat returns exactly one output beat with the
// method's statistics after the event. After reset the method table is swept
// to zero, all METHOD_SLOTS entries in turn, with in_stall_o high. One event is
// handled at a time, each step being one read-modify-write of the method
// table or the frame stack, whose single read port sets the pace: an enter
// or a dropped or empty event reads the method entry and then reports it, a
// matched leave passes through S_TOP and S_CLOSE (and S_PARENT when a caller
// frame gets the child time), and every frame unwound on a mismatched leave
// adds an S_TOP and an S_POP step. The next beat is taken once the
// previous result has left the output register.
module call_stack_time_profiler_top
  import cstp_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  wire cstp_in_t in_data_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output cstp_out_t     out_data_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_TOP    = 8'b0000_0100,
    S_POP    = 8'b0000_1000,
    S_CLOSE  = 8'b0001_0000,
    S_PARENT = 8'b0010_0000,
    S_ENTER  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  state_e          st_q, st_d;
  logic [MI_W-1:0] clr_q, clr_d;
  logic [DP_W-1:0] depth_q, depth_d;
  logic [63:0]     total_q, total_d;
  logic            out_valid_q, out_valid_d;
  cstp_out_t       out_q, out_d;
  logic [MI_W-1:0] m_q, m_d;
  logic [63:0]     ts_q, ts_d;
  status_e         stat_q, stat_d;
  logic [63:0]     run_q, run_d;

  cstp_mreq_t      mreq;
  cstp_freq_t      freq;
  cstp_mth_t       mrd;
  cstp_frame_t     frd;

  logic            acc_in;
  logic [MI_W-1:0] m_in;
  logic [DP_W-1:0] top_full, par_full;
  logic [SA_W-1:0] top_idx, par_idx;
  logic            stk_full;
  cstp_mth_t       nm;
  cstp_frame_t     nf;
  logic [63:0]     total_sum;

  function automatic cstp_out_t mk_out(input status_e s, input cstp_mth_t e,
                                       input logic [63:0] g, input logic [DP_W-1:0] d);
    cstp_out_t o;
    o.status       = s;
    o.calls        = e.calls;
    o.active_count = e.active;
    o.cum_time     = e.cum;
    o.outer_time   = e.outer;
    o.child_time   = e.child;
    o.flawed       = e.flawed;
    o.grand_total  = g;
    o.depth        = 7'(d);
    return o;
  endfunction

  cstp_mtab u_mtab (
    .clk_i   (clk_i),
    .req_i   (mreq),
    .rdata_o (mrd)
  );

  cstp_fstack u_fstack (
    .clk_i   (clk_i),
    .req_i   (freq),
    .rdata_o (frd)
  );

  // Handshake and stack addressing
  assign in_stall_o  = (st_q != S_IDLE) || out_valid_q;
  assign acc_in      = in_valid_i && !in_stall_o;
  assign m_in        = mth_idx(in_data_i.method_id);
  assign top_full    = depth_q - DP_W'(1);
  assign par_full    = depth_q - DP_W'(2);
  assign top_idx     = top_full[SA_W-1:0];
  assign par_idx     = par_full[SA_W-1:0];
  assign stk_full    = (depth_q >= DP_W'(STACK_FRAMES));
  assign total_sum   = total_q + run_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequence one event through the table and the stack
  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    depth_d     = depth_q;
    total_d     = total_q;
    out_d       = out_q;
    m_d         = m_q;
    ts_d        = ts_q;
    stat_d      = stat_q;
    run_d       = run_q;
    mreq        = '0;
    freq        = '0;
    nm          = mrd;
    nf          = frd;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (st_q)
      S_CLEAR: begin
        mreq.we    = 1'b1;
        mreq.waddr = clr_q;
        mreq.wdata = '0;
        clr_d      = clr_q + MI_W'(1);
        if (clr_q == MI_W'(METHOD_SLOTS - 1)) begin
          st_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (acc_in) begin
          m_d  = m_in;
          ts_d = in_data_i.timestamp;
          if (in_data_i.op == OP_ENTER) begin
            mreq.re    = 1'b1;
            mreq.raddr = m_in;
            if (stk_full) begin
              stat_d = ST_FULL;
              st_d   = S_FIN;
            end else begin
              st_d = S_ENTER;
            end
          end else if (depth_q == '0) begin
            mreq.re    = 1'b1;
            mreq.raddr = m_in;
            stat_d     = ST_EMPTY;
            st_d       = S_FIN;
          end else begin
            freq.re    = 1'b1;
            freq.raddr = top_idx;
            st_d       = S_TOP;
          end
        end
      end

      // Push the frame and count the call
      S_ENTER: begin
        nm.calls   = mrd.calls + 32'd1;
        nm.active  = mrd.active + 7'd1;
        mreq.we    = 1'b1;
        mreq.waddr = m_q;
        mreq.wdata = nm;
        nf.meth    = m_q;
        nf.entry   = ts_q;
        nf.child   = '0;
        freq.we    = 1'b1;
        freq.waddr = depth_q[SA_W-1:0];
        freq.wdata = nf;
        depth_d    = depth_q + DP_W'(1);
        out_d      = mk_out(ST_OK, nm, total_q, depth_q + DP_W'(1));
        out_valid_d = 1'b1;
        st_d       = S_IDLE;
      end

      // Compare the top frame with the leaving method
      S_TOP: begin
        mreq.re = 1'b1;
        if (frd.meth == m_q) begin
          mreq.raddr = m_q;
          run_d      = ts_q - frd.entry;
          st_d       = S_CLOSE;
        end else begin
          mreq.raddr = frd.meth;
          st_d       = S_POP;
        end
      end

      // Drop a mismatched frame and flag its method
      S_POP: begin
        nm.flawed  = 1'b1;
        nm.active  = mrd.active - 7'd1;
        mreq.we    = 1'b1;
        mreq.waddr = frd.meth;
        mreq.wdata = nm;
        depth_d    = top_full;
        if (depth_q == DP_W'(1)) begin
          mreq.re    = 1'b1;
          mreq.raddr = m_q;
          stat_d     = ST_EMPTY;
          st_d       = S_FIN;
        end else begin
          freq.re    = 1'b1;
          freq.raddr = par_idx;
          st_d       = S_TOP;
        end
      end

      // Close the matching frame and charge its time
      S_CLOSE: begin
        nm.active  = mrd.active - 7'd1;
        nm.cum     = mrd.cum + run_q;
        nm.child   = mrd.child + frd.child;
        if (nm.active == 7'd0) begin
          nm.outer = mrd.outer + run_q;
        end
        mreq.we    = 1'b1;
        mreq.waddr = m_q;
        mreq.wdata = nm;
        depth_d    = top_full;
        if (depth_q > DP_W'(1)) begin
          freq.re    = 1'b1;
          freq.raddr = par_idx;
          out_d      = mk_out(ST_OK, nm, total_q, top_full);
          st_d       = S_PARENT;
        end else begin
          total_d     = total_sum;
          out_d       = mk_out(ST_OK, nm, total_sum, top_full);
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end

      // Add the running time to the caller's child time
      S_PARENT: begin
        nf.child    = frd.child + run_q;
        freq.we     = 1'b1;
        freq.waddr  = top_idx;
        freq.wdata  = nf;
        out_valid_d = 1'b1;
        st_d        = S_IDLE;
      end

      // Report the unchanged entry
      S_FIN: begin
        out_d       = mk_out(stat_q, mrd, total_q, depth_q);
        out_valid_d = 1'b1;
        st_d        = S_IDLE;
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      depth_q     <= depth_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and event holding registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    m_q    <= m_d;
    ts_q   <= ts_d;
    stat_q <= stat_d;
    run_q  <= run_d;
  end

endmodule

`default_nettype wire

### hw/rtl/cstp_chk.sv
// Port checker for the call stack time profiler, bound to the top level.
// Depends on cstp_pkg for the beat types and stack size.
`timescale 1ns / 1ps
`default_nettype none

module cstp_chk
  import cstp_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input wire cstp_out_t out_data_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // One event at a time: stall rises after each accepted beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an event is in flight");

  // A dropped enter only happens on a full stack
  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |-> out_data_o.depth == 7'(STACK_FRAMES))
    else $error("full status with stack not full");

  // An empty or failed leave leaves the stack empty
  a_empty_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |-> out_data_o.depth == 7'd0)
    else $error("empty status with frames on the stack");

endmodule

bind call_stack_time_profiler_top cstp_chk u_cstp_chk (.*);

`default_nettype wire

### tb/call_stack_time_profiler_top_test.sv
// Self-checking bench for the call stack time profiler: random enter/leave streams with
// random gaps and stalls, scored against a behavioural model of the shadow stack.
// Depends on cstp_pkg and call_stack_time_profiler_top.
`timescale 1ns / 1ps

module call_stack_time_profiler_top_test;
  import cstp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  cstp_in_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cstp_out_t out_data;

  call_stack_time_profiler_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  cstp_in_t    pending_events[$];
  cstp_out_t   stats_due[$];
  logic [7:0]  open_calls[$];
  logic [63:0] gen_now;
  int unsigned n_total;
  int unsigned accepted;
  int unsigned beats_seen;
  int unsigned mismatches;

  // Model of the per-method table and the shadow stack
  bit [31:0]       tbl_calls  [METHOD_SLOTS];
  bit [6:0]        tbl_active [METHOD_SLOTS];
  bit              tbl_flawed [METHOD_SLOTS];
  bit [63:0]       tbl_cum    [METHOD_SLOTS];
  bit [63:0]       tbl_outer  [METHOD_SLOTS];
  bit [63:0]       tbl_child  [METHOD_SLOTS];
  bit [MI_W-1:0]   fr_meth    [STACK_FRAMES];
  bit [63:0]       fr_entry   [STACK_FRAMES];
  bit [63:0]       fr_child   [STACK_FRAMES];
  int unsigned     sp;
  bit [63:0]       grand_sum;

  // Apply one accepted event to the model and queue the statistics it yields
  function automatic void profile_event(input cstp_in_t ev);
    int unsigned m;
    int unsigned p;
    int unsigned top;
    logic [63:0] run;
    status_e     st;
    cstp_out_t   r;
    m  = ev.method_id % METHOD_SLOTS;
    st = ST_OK;
    if (ev.op == OP_ENTER) begin
      if (sp >= STACK_FRAMES) begin
        st = ST_FULL;
      end else begin
        tbl_calls[m]  = tbl_calls[m] + 32'd1;
        tbl_active[m] = tbl_active[m] + 7'd1;
        fr_meth[sp]   = MI_W'(m);
        fr_entry[sp]  = ev.timestamp;
        fr_child[sp]  = '0;
        sp++;
      end
    end else if (sp == 0) begin
      st = ST_EMPTY;
    end else begin
      // Unwind frames of other methods, flagging them
      while (sp > 0 && 32'(fr_meth[sp-1]) != m) begin
        p = 32'(fr_meth[sp-1]);
        tbl_flawed[p] = 1'b1;
        tbl_active[p] = tbl_active[p] - 7'd1;
        sp--;
      end
      if (sp == 0) begin
        st = ST_EMPTY;
      end else begin
        top = sp - 1;
        run = ev.timestamp - fr_entry[top];
        tbl_active[m] = tbl_active[m] - 7'd1;
        tbl_cum[m]    = tbl_cum[m] + run;
        tbl_child[m]  = tbl_child[m] + fr_child[top];
        if (tbl_active[m] == 0) tbl_outer[m] = tbl_outer[m] + run;
        if (top > 0) fr_child[top-1] = fr_child[top-1] + run;
        else grand_sum = grand_sum + run;
        sp = top;
      end
    end
    r.status       = st;
    r.calls        = tbl_calls[m];
    r.active_count = tbl_active[m];
    r.cum_time     = tbl_cum[m];
    r.outer_time   = tbl_outer[m];
    r.child_time   = tbl_child[m];
    r.flawed       = tbl_flawed[m];
    r.grand_total  = grand_sum;
    r.depth        = 7'(sp);
    stats_due.push_back(r);
  endfunction

  // Queue one event and track which calls the stream leaves open
  function automatic void queue_event(input op_e op, input logic [7:0] id,
                                      input logic [63:0] ts);
    cstp_in_t ev;
    ev.op        = op;
    ev.method_id = id;
    ev.timestamp = ts;
    pending_events.push_back(ev);
    if (op == OP_ENTER) begin
      if (open_calls.size() < STACK_FRAMES) open_calls.push_back(id);
    end else begin
      while (open_calls.size() > 0 && open_calls[open_calls.size()-1] != id)
        open_calls.delete(open_calls.size() - 1);
      if (open_calls.size() > 0) open_calls.delete(open_calls.size() - 1);
    end
  endfunction

  // Mostly a small set of methods, so that recursion and re-entry are common
  function automatic logic [7:0] pick_method();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] absent_method();
    logic [7:0] id;
    bit         hit;
    do begin
      id  = 8'($urandom_range(0, 255));
      hit = 1'b0;
      foreach (open_calls[i]) if (open_calls[i] == id) hit = 1'b1;
    end while (hit);
    return id;
  endfunction

  // Advance the trace clock: small steps, some large ones, rare random jumps
  function automatic logic [63:0] next_stamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) gen_now = gen_now + 64'($urandom_range(0, 60));
    else if (r < 97) gen_now = gen_now + 64'($urandom);
    else gen_now = {$urandom, $urandom};
    return gen_now;
  endfunction

  function automatic int unsigned pick_pause(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void build_stimulus();
    bit first_dive;
    // Directed: empty leave, extreme ids and stamps, recursion, partial and full
    // unwind, timestamp wrap
    queue_event(OP_LEAVE, 8'd0,   64'd0);
    queue_event(OP_ENTER, 8'd0,   64'd0);
    queue_event(OP_ENTER, 8'd255, 64'd10);
    queue_event(OP_LEAVE, 8'd255, 64'd30);
    queue_event(OP_LEAVE, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
    queue_event(OP_ENTER, 8'd3,   64'd100);
    queue_event(OP_ENTER, 8'd3,   64'd150);
    queue_event(OP_LEAVE, 8'd3,   64'd170);
    queue_event(OP_LEAVE, 8'd3,   64'd400);
    queue_event(OP_ENTER, 8'd1,   64'd500);
    queue_event(OP_ENTER, 8'd2,   64'd510);
    queue_event(OP_LEAVE, 8'd1,   64'd530);
    queue_event(OP_ENTER, 8'd4,   64'd600);
    queue_event(OP_ENTER, 8'd5,   64'd610);
    queue_event(OP_LEAVE, 8'd9,   64'd620);
    queue_event(OP_ENTER, 8'd6,   64'hFFFF_FFFF_FFFF_FFF0);
    queue_event(OP_ENTER, 8'd7,   64'hFFFF_FFFF_FFFF_FFF8);
    queue_event(OP_LEAVE, 8'd7,   64'd8);
    queue_event(OP_LEAVE, 8'd6,   64'h8000_0000_0000_0000);
    queue_event(OP_LEAVE, 8'd200, 64'h5555_AAAA_5555_AAAA);
    gen_now    = 64'd1000;
    first_dive = 1'b1;
    n_total    = pending_events.size() + RANDOM_ITEMS;
    while (pending_events.size() < n_total) begin
      if (first_dive || $urandom_range(0, 999) < 5) begin
        // Fill the stack, overflow it, then unwind to the bottom or past it
        first_dive = 1'b0;
        while (open_calls.size() < STACK_FRAMES)
          queue_event(OP_ENTER, pick_method(), next_stamp());
        repeat ($urandom_range(1, 3)) queue_event(OP_ENTER, pick_method(), next_stamp());
        if ($urandom_range(0, 1) != 0) queue_event(OP_LEAVE, open_calls[0], next_stamp());
        else queue_event(OP_LEAVE, absent_method(), next_stamp());
      end else if ($urandom_range(0, 99) < 6) begin
        // Broken sequences and noise
        case ($urandom_range(0, 3))
          0: begin
            queue_event(OP_LEAVE, absent_method(), next_stamp());
          end
          1: begin
            if (open_calls.size() > 0)
              queue_event(OP_LEAVE, open_calls[$urandom_range(0, open_calls.size() - 1)],
                          next_stamp());
            else
              queue_event(OP_LEAVE, pick_method(), next_stamp());
          end
          2: begin
            queue_event(OP_ENTER, 8'($urandom), {$urandom, $urandom});
          end
          default: begin
            queue_event(OP_LEAVE, pick_method(), {$urandom, $urandom});
          end
        endcase
      end else if (open_calls.size() > 0 &&
                   $urandom_range(0, 23) < 6 + open_calls.size()) begin
        queue_event(OP_LEAVE, open_calls[open_calls.size()-1], next_stamp());
      end else begin
        queue_event(OP_ENTER, pick_method(), next_stamp());
      end
    end
  endfunction

  // Driver: offer queued events with random gaps, hold a stalled beat
  int unsigned gap_left;
  bit          send_calm;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        profile_event(in_data);
        accepted++;
        if (accepted % 150 == 0) send_calm = ($urandom_range(0, 3) == 0);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          in_data  <= pending_events.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so that the block backs up into its input
  int unsigned hold_cnt;
  bit          hold_done;

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && beats_seen >= HOLD_AT) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat %0d %s: expected %h, got %h", beats_seen, name, want, got);
    end
  endtask

  // Monitor: score each output beat against the oldest expectation
  int unsigned stall_left;
  bit          recv_calm;
  bit          want_stall;
  cstp_out_t   exp_beat;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (beats_seen % 150 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        if (stats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("beat %0d arrived with none expected", beats_seen);
        end else begin
          exp_beat = stats_due.pop_front();
          check_field("status",       64'(exp_beat.status),    64'(out_data.status));
          check_field("calls",        64'(exp_beat.calls),     64'(out_data.calls));
          check_field("active_count", 64'(exp_beat.active_count),
                      64'(out_data.active_count));
          check_field("cum_time",     exp_beat.cum_time,       out_data.cum_time);
          check_field("outer_time",   exp_beat.outer_time,     out_data.outer_time);
          check_field("child_time",   exp_beat.child_time,     out_data.child_time);
          check_field("flawed",       64'(exp_beat.flawed),    64'(out_data.flawed));
          check_field("grand_total",  exp_beat.grand_total,    out_data.grand_total);
          check_field("depth",        64'(exp_beat.depth),     64'(out_data.depth));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        want_stall = 1'b1;
      end else begin
        want_stall = 1'b0;
        stall_left = pick_pause(recv_calm);
      end
      out_stall <= want_stall || (hold_cnt != 0);
    end
  end

  // Sequence: build the stream, release reset, drain, report
  initial begin
    build_stimulus();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted < n_total) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung block
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
